// ===== rtl/hpd_pkg.sv =====
`timescale 1ns / 1ps

package hpd_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SAMPLE_BITS = 32;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DIM_W = 13;
    localparam int CMP_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int COORD_W = 20;
    localparam int RESP_W  = 31;
    localparam int OCT_W   = 3;
    localparam int CLASS_W = 6;
    localparam int BORDER_W = 11;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = OUT_PTR_W + 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FRAME_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_THRESHOLD    = 3'd2;
    localparam t_cfg_idx CFG_BORDER       = 3'd3;
    localparam t_cfg_idx CFG_OCTAVE       = 3'd4;
    localparam t_cfg_idx CFG_CLASS        = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        t_sample          upper;
        t_sample          middle;
    } t_ls_wr;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RESP_W-1:0]  resp;
        logic [OCT_W-1:0]   oct;
        logic [CLASS_W-1:0] cls;
    } t_key;

endpackage

// ===== rtl/hpd_line_store.sv =====
`timescale 1ns / 1ps

module hpd_line_store
    import hpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [COL_W-1:0] i_rd_addr,
    input  t_ls_wr           i_wr,
    output t_sample          o_upper,
    output t_sample          o_middle
);

    t_sample r_mem_upper  [MAX_WIDTH];
    t_sample r_mem_middle [MAX_WIDTH];

    t_sample            r_q_upper;
    t_sample            r_q_middle;
    t_sample            r_fwd_upper;
    t_sample            r_fwd_middle;
    logic               r_fwd;
    logic               r_hit;
    logic [COL_W:0]     r_fill;

    // Columns are always written as a prefix starting at zero, so a fill count
    // tells which entries hold data; the rest read as zero.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_upper[i_wr.addr]  <= i_wr.upper;
            r_mem_middle[i_wr.addr] <= i_wr.middle;
        end
        r_q_upper    <= r_mem_upper[i_rd_addr];
        r_q_middle   <= r_mem_middle[i_rd_addr];
        r_fwd_upper  <= i_wr.upper;
        r_fwd_middle <= i_wr.middle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_fwd  <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_fwd <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_hit <= {1'b0, i_rd_addr} < r_fill;
            if (i_wr.en && ({1'b0, i_wr.addr} >= r_fill)) begin
                r_fill <= {1'b0, i_wr.addr} + 1'b1;
            end
        end
    end

    always_comb begin
        if (r_fwd) begin
            o_upper  = r_fwd_upper;
            o_middle = r_fwd_middle;
        end else if (r_hit) begin
            o_upper  = r_q_upper;
            o_middle = r_q_middle;
        end else begin
            o_upper  = '0;
            o_middle = '0;
        end
    end

endmodule

// ===== rtl/hessian_peak_detector_3x3_unit.sv =====
`timescale 1ns / 1ps
// A peak for an accepted beat passes the stage 1 and stage 2 registers and the output
// queue before it is on the output. Throughput: one input beat per cycle while o_in_stall
// is low, set by the single read and write port of each line store; the output queue of
// four beats decouples output stalls from the pipeline.
// Reset (synchronous, active low) loads the register defaults, zeroes the row and column
// counters and the line store fill count; line store entries never written read as zero.

module hessian_peak_detector_3x3_unit
    import hpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_hessian_value,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_W-1:0]    o_key_x_doubled,
    output logic [COORD_W-1:0]    o_key_y_doubled,
    output logic [RESP_W-1:0]     o_peak_response,
    output logic [OCT_W-1:0]      o_key_octave,
    output logic [CLASS_W-1:0]    o_key_class
);

    // Configuration registers.
    logic [DIM_W-1:0]    r_cfg_width;
    logic [DIM_W-1:0]    r_cfg_height;
    t_sample             r_cfg_thr;
    logic [BORDER_W-1:0] r_cfg_border;
    logic [OCT_W-1:0]    r_cfg_oct;
    logic [CLASS_W-1:0]  r_cfg_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DIM_W'(640);
            r_cfg_height <= DIM_W'(480);
            r_cfg_thr    <= '0;
            r_cfg_border <= BORDER_W'(1);
            r_cfg_oct    <= '0;
            r_cfg_class  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[DIM_W-1:0];
                CFG_THRESHOLD:    r_cfg_thr    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_BORDER:       r_cfg_border <= i_cfg_data[BORDER_W-1:0];
                CFG_OCTAVE:       r_cfg_oct    <= i_cfg_data[OCT_W-1:0];
                CFG_CLASS:        r_cfg_class  <= i_cfg_data[CLASS_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size and border.
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] h_eff;
    logic [CMP_W-1:0] b_eff;

    always_comb begin
        if (CMP_W'(r_cfg_width) < CMP_W'(3)) begin
            w_eff = CMP_W'(3);
        end else if (CMP_W'(r_cfg_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(r_cfg_width);
        end
        if (CMP_W'(r_cfg_height) < CMP_W'(3)) begin
            h_eff = CMP_W'(3);
        end else if (CMP_W'(r_cfg_height) > CMP_W'(MAX_HEIGHT)) begin
            h_eff = CMP_W'(MAX_HEIGHT);
        end else begin
            h_eff = CMP_W'(r_cfg_height);
        end
        b_eff = (r_cfg_border == '0) ? CMP_W'(1) : CMP_W'(r_cfg_border);
    end

    // Stage 0: position of the incoming beat and the counters after it.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] s0_col;
    logic [ROW_W-1:0] s0_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [CMP_W-1:0] s0_cbase;
    logic [CMP_W-1:0] s0_rtmp;
    logic [CMP_W-1:0] s0_cnext;
    logic [CMP_W-1:0] s0_rnext;
    logic             in_accept;

    always_comb begin
        s0_cbase = i_frame_start ? '0 : CMP_W'(r_col);
        s0_rtmp  = i_frame_start ? '0 : CMP_W'(r_row);
        if (s0_cbase >= w_eff) begin
            s0_cbase = '0;
            s0_rtmp  = s0_rtmp + 1'b1;
        end
        if (s0_rtmp >= h_eff) begin
            s0_rtmp = '0;
        end
        s0_col = s0_cbase[COL_W-1:0];
        s0_row = s0_rtmp[ROW_W-1:0];

        s0_cnext = s0_cbase + 1'b1;
        s0_rnext = s0_rtmp;
        if (s0_cnext >= w_eff) begin
            s0_cnext = '0;
            s0_rnext = s0_rtmp + 1'b1;
            if (s0_rnext >= h_eff) begin
                s0_rnext = '0;
            end
        end
        n_col = s0_cnext[COL_W-1:0];
        n_row = s0_rnext[ROW_W-1:0];
    end

    // Output queue and credit check: never accept a beat that could not be queued.
    t_key                 r_q [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_q_wp;
    logic [OUT_PTR_W-1:0] r_q_rp;
    logic [OUT_CNT_W-1:0] r_q_cnt;
    logic                 r_s1_valid;
    logic                 r_s2_valid;
    logic [OUT_CNT_W:0]   busy;
    logic                 q_push;
    logic                 q_pop;
    t_key                 push_key;

    assign busy       = {1'b0, r_q_cnt} + (OUT_CNT_W+1)'(r_s1_valid)
                        + (OUT_CNT_W+1)'(r_s2_valid);
    assign o_in_stall = busy >= (OUT_CNT_W+1)'(OUT_DEPTH);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Stage 1 registers.
    t_sample          r_s1_val;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            if (in_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_val <= i_hessian_value;
        r_s1_col <= s0_col;
        r_s1_row <= s0_row;
    end

    // Line stores: read issued in stage 0, data and write-back in stage 1.
    t_sample ls_upper;
    t_sample ls_middle;
    t_ls_wr  ls_wr;

    always_comb begin
        ls_wr.en     = r_s1_valid;
        ls_wr.addr   = r_s1_col;
        ls_wr.upper  = ls_middle;
        ls_wr.middle = r_s1_val;
    end

    hpd_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (s0_col),
        .i_wr      (ls_wr),
        .o_upper   (ls_upper),
        .o_middle  (ls_middle)
    );

    // Window shift and border test in stage 1.
    t_sample          r_win [9];
    logic             r_s2_inb;
    logic [COL_W-1:0] r_s2_col;
    logic [ROW_W-1:0] r_s2_row;
    logic             s1_inb;

    // The centre sits one row and one column back; b <= idx <= size-1-b.
    assign s1_inb = (CMP_W'(r_s1_row) >= b_eff + 1'b1)
                 && (CMP_W'(r_s1_row) + b_eff <= h_eff)
                 && (CMP_W'(r_s1_col) >= b_eff + 1'b1)
                 && (CMP_W'(r_s1_col) + b_eff <= w_eff);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int k = 0; k < 9; k += 3) begin
                r_win[k]   <= r_win[k+1];
                r_win[k+1] <= r_win[k+2];
            end
            r_win[2] <= ls_upper;
            r_win[5] <= ls_middle;
            r_win[8] <= r_s1_val;
        end
        r_s2_inb <= s1_inb;
        r_s2_col <= r_s1_col - 1'b1;
        r_s2_row <= r_s1_row - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 2: peak test and result fields.
    t_sample          ctr;
    logic             peak;
    logic [COORD_W-1:0] x_odd;
    logic [COORD_W-1:0] y_odd;

    always_comb begin
        ctr  = r_win[4];
        peak = r_s2_inb && (ctr > r_cfg_thr);
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && !(ctr > r_win[k])) begin
                peak = 1'b0;
            end
        end

        x_odd = COORD_W'({r_s2_col, 1'b1}) << r_cfg_oct;
        y_odd = COORD_W'({r_s2_row, 1'b1}) << r_cfg_oct;
        push_key.x = x_odd - 1'b1;
        push_key.y = y_odd - 1'b1;

        if (ctr[SAMPLE_BITS-1]) begin
            // The most negative sample has no positive twin and saturates.
            if (ctr == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) begin
                push_key.resp = {RESP_W{1'b1}};
            end else begin
                push_key.resp = RESP_W'(-ctr);
            end
        end else begin
            push_key.resp = RESP_W'(ctr);
        end
        push_key.oct = r_cfg_oct;
        push_key.cls = r_cfg_class;
    end

    assign q_push = r_s2_valid && peak;
    assign q_pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_q_wp] <= push_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (q_push) begin
                r_q_wp <= r_q_wp + 1'b1;
            end
            if (q_pop) begin
                r_q_rp <= r_q_rp + 1'b1;
            end
            r_q_cnt <= r_q_cnt + OUT_CNT_W'(q_push) - OUT_CNT_W'(q_pop);
        end
    end

    assign o_out_valid     = r_q_cnt != '0;
    assign o_key_x_doubled = r_q[r_q_rp].x;
    assign o_key_y_doubled = r_q[r_q_rp].y;
    assign o_peak_response = r_q[r_q_rp].resp;
    assign o_key_octave    = r_q[r_q_rp].oct;
    assign o_key_class     = r_q[r_q_rp].cls;

endmodule

// ===== tb/hpd_keypoint_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both beat channels of the peak detector,
// predicts each keypoint beat from its own model of the line stores and the
// 3x3 window, and compares the output beats in order.
module hpd_keypoint_checker
    import hpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_sample               i_hessian_value,
    input  logic                  i_frame_start,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [COORD_W-1:0]    i_key_x_doubled,
    input  logic [COORD_W-1:0]    i_key_y_doubled,
    input  logic [RESP_W-1:0]     i_peak_response,
    input  logic [OCT_W-1:0]      i_key_octave,
    input  logic [CLASS_W-1:0]    i_key_class,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [DIM_W-1:0]    cfg_width;
    logic [DIM_W-1:0]    cfg_height;
    t_sample             cfg_thresh;
    logic [BORDER_W-1:0] cfg_border;
    logic [OCT_W-1:0]    cfg_oct;
    logic [CLASS_W-1:0]  cfg_cls;

    t_sample row_above [MAX_WIDTH];
    t_sample row_prev  [MAX_WIDTH];
    t_sample win [9];
    int      col_pos;
    int      row_pos;

    t_key expected_keys [$];
    int   mismatches = 0;

    function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Full-resolution coordinate in half-pixel units.
    function automatic logic [COORD_W-1:0] half_pel(int idx, logic [OCT_W-1:0] oct);
        longint s;
        longint full;
        s    = longint'(1) << oct;
        full = longint'(idx) * 2 * s + s - 1;
        return full[COORD_W-1:0];
    endfunction

    function automatic logic [RESP_W-1:0] abs_sat(t_sample s);
        longint m;
        m = s;
        if (m < 0) m = -m;
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        return m[RESP_W-1:0];
    endfunction

    task apply_reg;
        case (i_cfg_index)
            CFG_FRAME_WIDTH:  cfg_width  = i_cfg_data[DIM_W-1:0];
            CFG_FRAME_HEIGHT: cfg_height = i_cfg_data[DIM_W-1:0];
            CFG_THRESHOLD:    cfg_thresh = i_cfg_data;
            CFG_BORDER:       cfg_border = i_cfg_data[BORDER_W-1:0];
            CFG_OCTAVE:       cfg_oct    = i_cfg_data[OCT_W-1:0];
            CFG_CLASS:        cfg_cls    = i_cfg_data[CLASS_W-1:0];
            default: ;
        endcase
    endtask

    task predict_keypoint(input t_sample v, input logic fs);
        int      w;
        int      h;
        int      b;
        int      c;
        int      r;
        t_sample top_px;
        t_sample mid_px;
        t_sample centre;
        bit      peak;
        t_key    key;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        b = (cfg_border == 0) ? 1 : int'(cfg_border);
        if (fs) begin
            c = 0;
            r = 0;
        end else begin
            c = col_pos;
            r = row_pos;
        end
        // Counters left past the size by a register change wrap here.
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;

        top_px       = row_above[c];
        mid_px       = row_prev[c];
        row_above[c] = mid_px;
        row_prev[c]  = v;
        for (int k = 0; k < 9; k += 3) begin
            win[k]     = win[k + 1];
            win[k + 1] = win[k + 2];
        end
        win[2] = top_px;
        win[5] = mid_px;
        win[8] = v;

        // The window centre sits one row up and one column left of the new pixel.
        if (r >= 1 && c >= 1 && r - 1 >= b && r + b <= h && c - 1 >= b && c + b <= w) begin
            centre = win[4];
            peak   = centre > cfg_thresh;
            for (int k = 0; k < 9; k++)
                if (k != 4 && !(centre > win[k])) peak = 1'b0;
            if (peak) begin
                key.x    = half_pel(c - 1, cfg_oct);
                key.y    = half_pel(r - 1, cfg_oct);
                key.resp = abs_sat(centre);
                key.oct  = cfg_oct;
                key.cls  = cfg_cls;
                expected_keys.push_back(key);
            end
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task check_key;
        t_key want;
        if (expected_keys.size() == 0) begin
            $error("keypoint beat with no peak predicted: x=%0d y=%0d response=%0d",
                   i_key_x_doubled, i_key_y_doubled, i_peak_response);
            mismatches++;
        end else begin
            want = expected_keys.pop_front();
            if (i_key_x_doubled !== want.x) begin
                $error("key_x_doubled: expected %0d, actual %0d", want.x, i_key_x_doubled);
                mismatches++;
            end
            if (i_key_y_doubled !== want.y) begin
                $error("key_y_doubled: expected %0d, actual %0d", want.y, i_key_y_doubled);
                mismatches++;
            end
            if (i_peak_response !== want.resp) begin
                $error("peak_response: expected %0d, actual %0d", want.resp, i_peak_response);
                mismatches++;
            end
            if (i_key_octave !== want.oct) begin
                $error("key_octave: expected %0d, actual %0d", want.oct, i_key_octave);
                mismatches++;
            end
            if (i_key_class !== want.cls) begin
                $error("key_class: expected %0d, actual %0d", want.cls, i_key_class);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = DIM_W'(640);
            cfg_height = DIM_W'(480);
            cfg_thresh = '0;
            cfg_border = BORDER_W'(1);
            cfg_oct    = '0;
            cfg_cls    = '0;
            for (int k = 0; k < MAX_WIDTH; k++) begin
                row_above[k] = '0;
                row_prev[k]  = '0;
            end
            for (int k = 0; k < 9; k++) win[k] = '0;
            col_pos = 0;
            row_pos = 0;
            expected_keys.delete();
        end else begin
            if (i_cfg_we) apply_reg;
            if (i_in_valid && !i_in_stall) predict_keypoint(i_hessian_value, i_frame_start);
            if (i_out_valid && !i_out_stall) check_key;
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_keys.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hpd_pkg::*;

    typedef enum logic [1:0] {PACE_STEADY, PACE_LIGHT, PACE_BURSTY} t_pace;
    typedef enum logic [1:0] {VAL_NARROW, VAL_FULL, VAL_SPIKE, VAL_EXTREME} t_val_mode;

    // Indexes outside the register list; the block must ignore writes to them.
    localparam t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    localparam int RANDOM_BEATS = 560;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    t_cfg_idx              i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    t_sample               i_hessian_value = '0;
    logic                  i_frame_start   = 1'b0;
    logic                  i_out_stall     = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [COORD_W-1:0] o_key_x_doubled;
    logic [COORD_W-1:0] o_key_y_doubled;
    logic [RESP_W-1:0]  o_peak_response;
    logic [OCT_W-1:0]   o_key_octave;
    logic [CLASS_W-1:0] o_key_class;

    int    fail_count;
    int    pending;
    t_pace src_pace      = PACE_STEADY;
    t_pace sink_pace     = PACE_STEADY;
    int    sink_hold     = 0;
    int    beats_sent    = 0;
    int    keys_seen     = 0;
    int    settings_used = 0;

    hessian_peak_detector_3x3_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_hessian_value (i_hessian_value),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_key_x_doubled (o_key_x_doubled),
        .o_key_y_doubled (o_key_y_doubled),
        .o_peak_response (o_peak_response),
        .o_key_octave    (o_key_octave),
        .o_key_class     (o_key_class)
    );

    hpd_keypoint_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_hessian_value (i_hessian_value),
        .i_frame_start   (i_frame_start),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_key_x_doubled (o_key_x_doubled),
        .i_key_y_doubled (o_key_y_doubled),
        .i_peak_response (o_peak_response),
        .i_key_octave    (o_key_octave),
        .i_key_class     (o_key_class),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap(t_pace p);
        int roll;
        roll = $urandom_range(0, 15);
        case (p)
            PACE_LIGHT:  return (roll < 2) ? $urandom_range(1, 3) : 0;
            PACE_BURSTY: begin
                if (roll == 0) return $urandom_range(10, 40);
                if (roll < 6) return $urandom_range(1, 4);
                return 0;
            end
            default:     return 0;
        endcase
    endfunction

    function automatic int pick_hold(t_pace p);
        int roll;
        roll = $urandom_range(0, 19);
        case (p)
            PACE_LIGHT:  return (roll < 2) ? $urandom_range(1, 3) : 0;
            PACE_BURSTY: begin
                if (roll == 0) return $urandom_range(20, 60);
                if (roll < 5) return $urandom_range(1, 4);
                return 0;
            end
            default:     return 0;
        endcase
    endfunction

    function automatic t_sample pick_extreme();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh8000_0001;
            2:       return 32'sh7FFF_FFFF;
            3:       return 32'sh7FFF_FFFE;
            4:       return '0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic t_sample pick_sample(t_val_mode m);
        case (m)
            VAL_NARROW: return $signed($urandom_range(0, 15)) - 8;
            VAL_FULL:   return $urandom;
            VAL_SPIKE: begin
                if ($urandom_range(0, 19) == 0) return -$signed($urandom_range(1000, 32'h7FFF_FFFF));
                if ($urandom_range(0, 9) == 0) return $urandom_range(1000, 32'h7FFF_FFFF);
                return $urandom_range(0, 100);
            end
            default:    return pick_extreme();
        endcase
    endfunction

    function automatic t_sample pick_threshold(t_val_mode m);
        case (m)
            VAL_NARROW: return $signed($urandom_range(0, 14)) - 10;
            VAL_FULL:   return ($urandom_range(0, 3) == 0) ? 32'sh8000_0000 : $urandom;
            VAL_SPIKE:  return $urandom_range(0, 900);
            default:    return pick_extreme();
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_border();
        logic [BORDER_W-1:0] b;
        case ($urandom_range(0, 9))
            6:       b = '0;
            7:       b = BORDER_W'(2);
            8:       b = BORDER_W'(3);
            9:       b = BORDER_W'($urandom_range(4, 2047));
            default: b = BORDER_W'(1);
        endcase
        return ($urandom << BORDER_W) | b;
    endfunction

    // Output side: random stall runs, chosen again whenever the last run ends.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) keys_seen++;
        if (sink_hold == 0) sink_hold = pick_hold(sink_pace);
        if (sink_hold > 0) begin
            i_out_stall <= 1'b1;
            sink_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task drive_beat(input t_sample v, input logic fs);
        int gap;
        i_in_valid      <= 1'b1;
        i_hessian_value <= v;
        i_frame_start   <= fs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
        gap = pick_gap(src_pace);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task program_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only once every predicted keypoint has come out and the
    // pipeline has had time to finish pixels that produce nothing.
    task begin_phase;
        i_in_valid <= 1'b0;
        do begin
            while (pending != 0) @(posedge i_clk);
            repeat (8) @(posedge i_clk);
        end while (pending != 0);
        settings_used++;
    endtask

    task feed(input int n, input t_val_mode m, input logic lead_fs);
        for (int i = 0; i < n; i++) drive_beat(pick_sample(m), lead_fs && i == 0);
    endtask

    task send_grid(input t_sample centre, input t_sample ring);
        for (int k = 0; k < 9; k++) drive_beat((k == 4) ? centre : ring, k == 0);
    endtask

    initial begin
        int        base;
        int        fw;
        int        fh;
        int        w_eff;
        int        h_eff;
        int        len;
        int        stray;
        logic      lead_fs;
        t_val_mode mode;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default threshold, border, octave and class on a narrow frame over
        // freshly cleared line stores.
        src_pace  = PACE_LIGHT;
        sink_pace <= PACE_LIGHT;
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 8);
        feed(40, VAL_SPIKE, 1'b1);

        // Smallest frame with the sample extremes around its one interior pixel.
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 3);
        program_reg(CFG_FRAME_HEIGHT, 3);
        program_reg(CFG_BORDER, 1);
        program_reg(CFG_THRESHOLD, 32'h8000_0000);
        program_reg(CFG_OCTAVE, 0);
        program_reg(CFG_CLASS, 0);
        send_grid(32'sh7FFF_FFFF, 32'sh8000_0000);
        begin_phase;
        program_reg(CFG_OCTAVE, 7);
        program_reg(CFG_CLASS, 63);
        send_grid(32'sh8000_0001, 32'sh8000_0000);
        // A centre equal to the threshold is not a peak.
        begin_phase;
        program_reg(CFG_THRESHOLD, 5);
        send_grid(5, 4);
        begin_phase;
        program_reg(CFG_THRESHOLD, 32'h7FFF_FFFF);
        feed(9, VAL_EXTREME, 1'b1);

        // Zero border behaves as one.
        src_pace  = PACE_BURSTY;
        sink_pace <= PACE_BURSTY;
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, ($urandom << DIM_W) | 5);
        program_reg(CFG_FRAME_HEIGHT, ($urandom << DIM_W) | 5);
        program_reg(CFG_BORDER, $urandom << BORDER_W);
        program_reg(CFG_THRESHOLD, -32'sd6);
        program_reg(CFG_OCTAVE, ($urandom << OCT_W) | 3);
        program_reg(CFG_CLASS, ($urandom << CLASS_W) | 9);
        feed(50, VAL_NARROW, 1'b1);

        // Border wider than the frame leaves no candidate.
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 8);
        program_reg(CFG_FRAME_HEIGHT, 8);
        program_reg(CFG_BORDER, 2047);
        feed(64, VAL_NARROW, 1'b1);

        // Sizes below three clamp to three; spare indexes must change nothing.
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, ($urandom << DIM_W) | 1);
        program_reg(CFG_FRAME_HEIGHT, $urandom << DIM_W);
        program_reg(CFG_BORDER, 1);
        program_reg(CFG_SPARE_LO, $urandom);
        program_reg(CFG_SPARE_HI, $urandom);
        feed(18, VAL_NARROW, 1'b1);
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 2);
        program_reg(CFG_FRAME_HEIGHT, 2);
        feed(18, VAL_NARROW, 1'b1);

        // Shrink the frame while the counters are deep inside a larger one.
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 10);
        program_reg(CFG_FRAME_HEIGHT, 10);
        feed(57, VAL_NARROW, 1'b1);
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 5);
        program_reg(CFG_FRAME_HEIGHT, 4);
        feed(40, VAL_NARROW, 1'b0);

        // Widest rows: the column count climbs past any narrower frame.
        src_pace  = PACE_LIGHT;
        sink_pace <= PACE_LIGHT;
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 4096);
        program_reg(CFG_FRAME_HEIGHT, 3);
        program_reg(CFG_BORDER, 1);
        program_reg(CFG_THRESHOLD, 200);
        program_reg(CFG_OCTAVE, 0);
        program_reg(CFG_CLASS, 21);
        feed(150, VAL_SPIKE, 1'b1);

        // Sizes above the maximum clamp to it.
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 6000);
        program_reg(CFG_FRAME_HEIGHT, 8191);
        feed(20, VAL_FULL, 1'b1);

        // Tallest frame at the top octave, down its first rows.
        begin_phase;
        program_reg(CFG_FRAME_WIDTH, 3);
        program_reg(CFG_FRAME_HEIGHT, 4096);
        program_reg(CFG_OCTAVE, 7);
        program_reg(CFG_THRESHOLD, -32'sd3);
        feed(3 * 40 + 6, VAL_NARROW, 1'b1);

        // Random settings, mostly whole frames, with truncated frames and stray
        // frame starts mixed in.
        base = beats_sent;
        while (beats_sent - base < RANDOM_BEATS) begin
            begin_phase;
            src_pace  = t_pace'($urandom_range(0, 2));
            sink_pace <= t_pace'($urandom_range(0, 2));
            fw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            fh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            program_reg(CFG_FRAME_WIDTH, ($urandom << DIM_W) | fw);
            program_reg(CFG_FRAME_HEIGHT, ($urandom << DIM_W) | fh);
            w_eff = (fw < 3) ? 3 : fw;
            h_eff = (fh < 3) ? 3 : fh;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: mode = VAL_NARROW;
                10, 11, 12, 13, 14:           mode = VAL_SPIKE;
                15, 16, 17:                   mode = VAL_FULL;
                default:                      mode = VAL_EXTREME;
            endcase
            if ($urandom_range(0, 3) != 0) program_reg(CFG_THRESHOLD, pick_threshold(mode));
            if ($urandom_range(0, 1) != 0) program_reg(CFG_BORDER, pick_border());
            if ($urandom_range(0, 1) != 0)
                program_reg(CFG_OCTAVE, ($urandom << OCT_W) | $urandom_range(0, 7));
            if ($urandom_range(0, 1) != 0)
                program_reg(CFG_CLASS, ($urandom << CLASS_W) | $urandom_range(0, 63));
            repeat ($urandom_range(1, 3)) begin
                len = w_eff * h_eff;
                if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
                stray   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : -1;
                lead_fs = ($urandom_range(0, 7) != 0);
                for (int i = 0; i < len; i++)
                    drive_beat(pick_sample(mode), (i == 0 && lead_fs) || i == stray);
            end
        end

        begin_phase;
        repeat (20) @(posedge i_clk);

        $display("Checked %0d keypoint beats from %0d pixel beats over %0d register settings.",
                 keys_seen, beats_sent, settings_used);
        $display("Frames ranged from 3x3 to 4096 wide and 4096 tall, borders 0 to 2047.");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hpd_pkg.sv
rtl/hpd_line_store.sv
rtl/hessian_peak_detector_3x3_unit.sv
tb/hpd_keypoint_checker.sv
tb/tb_top.sv
